[src/ssp_pkg.sv]
// Shared constants, register indexes and item types for the sprite projection block.
package ssp_pkg;

  localparam int SCREEN_WIDTH   = 640;
  localparam int SCREEN_HEIGHT  = 480;
  localparam int HEIGHT_DIVISOR = 1;
  localparam int WIDTH_DIVISOR  = 1;

  localparam int HALF_W  = SCREEN_WIDTH / 2;
  localparam int HALF_H  = SCREEN_HEIGHT / 2;
  localparam int DIV_MAX = (HEIGHT_DIVISOR > WIDTH_DIVISOR) ? HEIGHT_DIVISOR : WIDTH_DIVISOR;

  // Numerator widths of the second divider lanes.
  localparam int SXN_W = $clog2(HALF_W + 1) + 33;
  localparam int SHN_W = $clog2(SCREEN_HEIGHT + 1) + 16;
  localparam int VMN_W = 32;
  localparam int QW_A  = (SXN_W > SHN_W) ? SXN_W : SHN_W;
  localparam int QW    = (QW_A > VMN_W) ? QW_A : VMN_W;
  localparam int DV_W  = 32 + $clog2(DIV_MAX + 1);
  localparam int SP_W  = QW + 3;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VSHIFT  = 3'd6;

  typedef struct packed {
    logic signed [31:0] sprite_pos_x;
    logic signed [31:0] sprite_pos_y;
  } ssp_in_t;

  typedef struct packed {
    logic signed [31:0] depth;
    logic signed [15:0] screen_center_x;
    logic [14:0]        span_height;
    logic [14:0]        span_width;
    logic [14:0]        row_start;
    logic signed [15:0] row_end;
    logic [14:0]        col_start;
    logic signed [15:0] col_end;
    logic               divide_fault;
  } ssp_out_t;

endpackage

[src/ssp_in_if.sv]
// Handshake channel that carries one sprite position item.
interface ssp_in_if import ssp_pkg::*; ();
  logic    valid;
  logic    ready;
  ssp_in_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[src/ssp_out_if.sv]
// Handshake channel that carries one projected sprite result item.
interface ssp_out_if import ssp_pkg::*; ();
  logic     valid;
  logic     ready;
  ssp_out_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[src/sprite_screen_projection.sv]
// Sprite camera projection: transform, two pipelined dividers and span clamping.
//
// Items enter on item_i as a sprite world position in Q16.16 and leave on result_o
// as the projected depth, center column, sizes and clamped draw spans. Camera
// registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must write them only while idle, which the block itself does not enforce.
// The pipeline accepts one item per cycle while the result is not stalled. It
// holds two bit-serial pipelined dividers: one of 32 stages for the camera-space
// coordinates and one of QW stages for the screen quantities.
// Every stage advances together; when the result is held by a stalled receiver,
// the whole pipeline holds and item_i.ready is low, so nothing is lost or
// repeated. Reset clears all valid bits and loads the default camera.
// A zero determinant or zero depth yields a result with only divide_fault set.
module sprite_screen_projection import ssp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  ssp_in_if.sink               item_i,
  ssp_out_if.source            result_o
);

  typedef struct packed {
    logic [63:0] r_tx;
    logic [63:0] r_ty;
    logic [31:0] nb_tx;
    logic [31:0] nb_ty;
    logic [31:0] q_tx;
    logic [31:0] q_ty;
    logic [63:0] ud;
    logic        neg_tx;
    logic        neg_ty;
    logic        ovf_tx;
    logic        ovf_ty;
    logic        fault;
  } div1_t;

  typedef struct packed {
    logic [3:0][DV_W-1:0] r;
    logic [3:0][QW-1:0]   n;
    logic [3:0][QW-1:0]   q;
    logic [3:0][DV_W-1:0] d;
    logic signed [31:0]   ty;
    logic                 neg_sx;
    logic                 neg_vm;
    logic                 fault;
  } div2_t;

  localparam logic signed [SP_W-1:0] S16_MAX = SP_W'(32767);
  localparam logic signed [SP_W-1:0] S16_MIN = -SP_W'(32768);
  localparam logic signed [SP_W-1:0] LIM_H   = SP_W'(SCREEN_HEIGHT - 1);
  localparam logic signed [SP_W-1:0] LIM_W   = SP_W'(SCREEN_WIDTH - 1);

  function automatic logic signed [31:0] sat_q16(input logic ovf, input logic neg,
                                                 input logic [31:0] mag);
    logic signed [31:0] res;
    if (ovf) begin
      res = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg) begin
      res = (mag > 32'h8000_0000) ? 32'sh8000_0000 : $signed(-mag);
    end else begin
      res = mag[31] ? 32'sh7FFF_FFFF : $signed(mag);
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] diff;
    diff = {a[31], a} - {b[31], b};
    if (diff[32] != diff[31]) begin
      return diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return diff[31:0];
  endfunction

  function automatic logic [63:0] abs65(input logic signed [64:0] v);
    logic [64:0] m;
    m = v[64] ? -v : v;
    return m[63:0];
  endfunction

  function automatic logic signed [15:0] sat_s16(input logic signed [SP_W-1:0] v);
    if (v > S16_MAX) return 16'sh7FFF;
    if (v < S16_MIN) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [14:0] sat_u15(input logic signed [SP_W-1:0] v);
    if (v > S16_MAX) return 15'h7FFF;
    if (v < 0) return 15'h0;
    return v[14:0];
  endfunction

  // Configuration registers.
  logic signed [31:0] cam_x_q, cam_y_q, dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic signed [15:0] vshift_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q   <= '0;
      cam_y_q   <= '0;
      dir_x_q   <= 32'sd65536;
      dir_y_q   <= '0;
      plane_x_q <= '0;
      plane_y_q <= 32'sd43253;
      vshift_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAM_X:   cam_x_q   <= cfg_wdata_i;
        CFG_CAM_Y:   cam_y_q   <= cfg_wdata_i;
        CFG_DIR_X:   dir_x_q   <= cfg_wdata_i;
        CFG_DIR_Y:   dir_y_q   <= cfg_wdata_i;
        CFG_PLANE_X: plane_x_q <= cfg_wdata_i;
        CFG_PLANE_Y: plane_y_q <= cfg_wdata_i;
        CFG_VSHIFT:  vshift_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // The determinant depends on the camera alone.
  logic signed [63:0] det_pa_q, det_pb_q;
  logic signed [64:0] det_q;

  always_ff @(posedge clk_i) begin
    det_pa_q <= plane_x_q * dir_y_q;
    det_pb_q <= dir_x_q * plane_y_q;
    det_q    <= {det_pa_q[63], det_pa_q} - {det_pb_q[63], det_pb_q};
  end

  logic en;
  logic out_vld_q;
  assign en           = !out_vld_q || result_o.ready;
  assign item_i.ready = en;

  logic                 vld_a_q, vld_b_q, vld_c_q, vld_d_q;
  logic [32:0]          v1_q;
  logic                 vld_f_q, vld_g_q;
  logic [QW:0]          v2_q;
  logic                 vld_i_q, vld_j_q;

  logic signed [31:0]   dx_a_q, dy_a_q;
  logic signed [63:0]   p0_b_q, p1_b_q, p2_b_q, p3_b_q;
  logic signed [64:0]   txn_c_q, tyn_c_q;
  logic                 fault_c_q;
  logic [63:0]          un_tx_d_q, un_ty_d_q, ud_d_q;
  logic                 neg_tx_d_q, neg_ty_d_q, fault_d_q;
  div1_t                d1_q [33];
  div1_t                d1_d [33];
  logic signed [31:0]   tx_f_q, ty_f_q;
  logic                 fault_f_q;
  logic signed [32:0]   sum_g_q;
  logic [31:0]          aty_g_q;
  logic signed [31:0]   ty_g_q;
  logic                 neg_vm_g_q, fault_g_q;
  div2_t                d2_q [QW+1];
  div2_t                d2_d [QW+1];
  logic signed [SP_W-1:0] sx_i_q, vm_i_q, sh_i_q, sw_i_q;
  logic signed [31:0]   ty_i_q, ty_j_q;
  logic                 fault_i_q, fault_j_q;
  logic signed [SP_W-1:0] sx_j_q, sh_j_q, sw_j_q, rs_j_q, re_j_q, cs_j_q, ce_j_q;
  ssp_out_t             out_q;

  logic [32:0]          abs_sum;
  logic [15:0]          abs_vs;
  logic signed [SP_W-1:0] sxq, vmq;

  always_comb begin
    d1_d[0] = d1_q[0];
    for (int k = 0; k < 32; k++) begin
      logic [64:0] t_tx, t_ty;
      logic        ge_tx, ge_ty;
      t_tx  = {d1_q[k].r_tx, d1_q[k].nb_tx[31]};
      t_ty  = {d1_q[k].r_ty, d1_q[k].nb_ty[31]};
      ge_tx = t_tx >= {1'b0, d1_q[k].ud};
      ge_ty = t_ty >= {1'b0, d1_q[k].ud};
      d1_d[k+1]       = d1_q[k];
      d1_d[k+1].r_tx  = ge_tx ? 64'(t_tx - {1'b0, d1_q[k].ud}) : t_tx[63:0];
      d1_d[k+1].r_ty  = ge_ty ? 64'(t_ty - {1'b0, d1_q[k].ud}) : t_ty[63:0];
      d1_d[k+1].nb_tx = {d1_q[k].nb_tx[30:0], 1'b0};
      d1_d[k+1].nb_ty = {d1_q[k].nb_ty[30:0], 1'b0};
      d1_d[k+1].q_tx  = {d1_q[k].q_tx[30:0], ge_tx};
      d1_d[k+1].q_ty  = {d1_q[k].q_ty[30:0], ge_ty};
    end
  end

  always_comb begin
    d2_d[0] = d2_q[0];
    for (int k = 0; k < QW; k++) begin
      d2_d[k+1] = d2_q[k];
      for (int l = 0; l < 4; l++) begin
        logic [DV_W:0] t;
        logic          ge;
        t  = {d2_q[k].r[l], d2_q[k].n[l][QW-1]};
        ge = t >= {1'b0, d2_q[k].d[l]};
        d2_d[k+1].r[l] = ge ? DV_W'(t - {1'b0, d2_q[k].d[l]}) : t[DV_W-1:0];
        d2_d[k+1].n[l] = {d2_q[k].n[l][QW-2:0], 1'b0};
        d2_d[k+1].q[l] = {d2_q[k].q[l][QW-2:0], ge};
      end
    end
  end

  assign abs_sum = sum_g_q[32] ? 33'(-sum_g_q) : 33'(sum_g_q);
  assign abs_vs  = vshift_q[15] ? 16'(-vshift_q) : 16'(vshift_q);
  assign sxq     = $signed(SP_W'(d2_q[QW].q[0]));
  assign vmq     = $signed(SP_W'(d2_q[QW].q[1]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q   <= 1'b0;
      vld_b_q   <= 1'b0;
      vld_c_q   <= 1'b0;
      vld_d_q   <= 1'b0;
      v1_q      <= '0;
      vld_f_q   <= 1'b0;
      vld_g_q   <= 1'b0;
      v2_q      <= '0;
      vld_i_q   <= 1'b0;
      vld_j_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_a_q   <= item_i.valid;
      vld_b_q   <= vld_a_q;
      vld_c_q   <= vld_b_q;
      vld_d_q   <= vld_c_q;
      v1_q      <= {v1_q[31:0], vld_d_q};
      vld_f_q   <= v1_q[32];
      vld_g_q   <= vld_f_q;
      v2_q      <= {v2_q[QW-1:0], vld_g_q};
      vld_i_q   <= v2_q[QW];
      vld_j_q   <= vld_i_q;
      out_vld_q <= vld_j_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_a_q <= sat_sub(item_i.data.sprite_pos_x, cam_x_q);
      dy_a_q <= sat_sub(item_i.data.sprite_pos_y, cam_y_q);

      p0_b_q <= dir_y_q * dx_a_q;
      p1_b_q <= dir_x_q * dy_a_q;
      p2_b_q <= plane_x_q * dy_a_q;
      p3_b_q <= plane_y_q * dx_a_q;

      txn_c_q   <= {p0_b_q[63], p0_b_q} - {p1_b_q[63], p1_b_q};
      tyn_c_q   <= {p2_b_q[63], p2_b_q} - {p3_b_q[63], p3_b_q};
      fault_c_q <= (det_q == '0);

      un_tx_d_q  <= abs65(txn_c_q);
      un_ty_d_q  <= abs65(tyn_c_q);
      ud_d_q     <= abs65(det_q);
      neg_tx_d_q <= txn_c_q[64] ^ det_q[64];
      neg_ty_d_q <= tyn_c_q[64] ^ det_q[64];
      fault_d_q  <= fault_c_q;

      d1_q[0].r_tx   <= {16'h0, un_tx_d_q[63:16]};
      d1_q[0].r_ty   <= {16'h0, un_ty_d_q[63:16]};
      d1_q[0].nb_tx  <= {un_tx_d_q[15:0], 16'h0};
      d1_q[0].nb_ty  <= {un_ty_d_q[15:0], 16'h0};
      d1_q[0].q_tx   <= '0;
      d1_q[0].q_ty   <= '0;
      d1_q[0].ud     <= ud_d_q;
      d1_q[0].neg_tx <= neg_tx_d_q;
      d1_q[0].neg_ty <= neg_ty_d_q;
      d1_q[0].ovf_tx <= {16'h0, un_tx_d_q} >= {ud_d_q, 16'h0};
      d1_q[0].ovf_ty <= {16'h0, un_ty_d_q} >= {ud_d_q, 16'h0};
      d1_q[0].fault  <= fault_d_q;
      for (int k = 1; k <= 32; k++) begin
        d1_q[k] <= d1_d[k];
      end

      tx_f_q    <= sat_q16(d1_q[32].ovf_tx, d1_q[32].neg_tx, d1_q[32].q_tx);
      ty_f_q    <= sat_q16(d1_q[32].ovf_ty, d1_q[32].neg_ty, d1_q[32].q_ty);
      fault_f_q <= d1_q[32].fault;

      sum_g_q    <= {tx_f_q[31], tx_f_q} + {ty_f_q[31], ty_f_q};
      aty_g_q    <= ty_f_q[31] ? 32'(-ty_f_q) : 32'(ty_f_q);
      ty_g_q     <= ty_f_q;
      neg_vm_g_q <= vshift_q[15] ^ ty_f_q[31];
      fault_g_q  <= fault_f_q || (ty_f_q == '0);

      d2_q[0].r      <= '0;
      d2_q[0].q      <= '0;
      d2_q[0].n[0]   <= QW'(HALF_W) * QW'(abs_sum);
      d2_q[0].n[1]   <= QW'({abs_vs, 16'h0});
      d2_q[0].n[2]   <= QW'(SCREEN_HEIGHT) << 16;
      d2_q[0].n[3]   <= QW'(SCREEN_HEIGHT) << 16;
      d2_q[0].d[0]   <= DV_W'(aty_g_q);
      d2_q[0].d[1]   <= DV_W'(aty_g_q);
      d2_q[0].d[2]   <= DV_W'(aty_g_q) * DV_W'(HEIGHT_DIVISOR);
      d2_q[0].d[3]   <= DV_W'(aty_g_q) * DV_W'(WIDTH_DIVISOR);
      d2_q[0].ty     <= ty_g_q;
      d2_q[0].neg_sx <= sum_g_q[32] ^ ty_g_q[31];
      d2_q[0].neg_vm <= neg_vm_g_q;
      d2_q[0].fault  <= fault_g_q;
      for (int k = 1; k <= QW; k++) begin
        d2_q[k] <= d2_d[k];
      end

      sx_i_q    <= d2_q[QW].neg_sx ? -sxq : sxq;
      vm_i_q    <= d2_q[QW].neg_vm ? -vmq : vmq;
      sh_i_q    <= $signed(SP_W'(d2_q[QW].q[2]));
      sw_i_q    <= $signed(SP_W'(d2_q[QW].q[3]));
      ty_i_q    <= d2_q[QW].ty;
      fault_i_q <= d2_q[QW].fault;

      sx_j_q    <= sx_i_q;
      sh_j_q    <= sh_i_q;
      sw_j_q    <= sw_i_q;
      rs_j_q    <= SP_W'(HALF_H) + vm_i_q - (sh_i_q >>> 1);
      re_j_q    <= SP_W'(HALF_H) + vm_i_q + (sh_i_q >>> 1);
      cs_j_q    <= sx_i_q - (sw_i_q >>> 1);
      ce_j_q    <= sx_i_q + (sw_i_q >>> 1);
      ty_j_q    <= ty_i_q;
      fault_j_q <= fault_i_q;

      if (fault_j_q) begin
        out_q <= '{divide_fault: 1'b1, default: '0};
      end else begin
        out_q.depth           <= ty_j_q;
        out_q.screen_center_x <= sat_s16(sx_j_q);
        out_q.span_height     <= sat_u15(sh_j_q);
        out_q.span_width      <= sat_u15(sw_j_q);
        out_q.row_start       <= sat_u15(rs_j_q);
        out_q.row_end         <= sat_s16((re_j_q > LIM_H) ? LIM_H : re_j_q);
        out_q.col_start       <= sat_u15(cs_j_q);
        out_q.col_end         <= sat_s16((ce_j_q > LIM_W) ? LIM_W : ce_j_q);
        out_q.divide_fault    <= 1'b0;
      end
    end
  end

  assign result_o.valid = out_vld_q;
  assign result_o.data  = out_q;

endmodule
